// ===== design/sap_pkg.sv =====
// Shared types, constants and table-building functions of the stereo all-pass phaser.
`default_nettype none
package sap_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int PHASE_W      = 32;
    localparam int STEP_W       = 24;
    localparam int FREQ_W       = 23;
    localparam int GAIN_W       = 17;
    localparam int FB_W         = 16;
    localparam int LFO_W        = 25;
    localparam int K_W          = 25;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int CORDIC_STEPS = 30;

    localparam longint CORDIC_GAIN = 64'sd652032874;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint SAMPLE_MAX  = 64'sd8388607;
    localparam longint SAMPLE_MIN  = -64'sd8388608;

    localparam logic [STEP_W-1:0] RST_PHASE_STEP = 24'd44739;
    localparam logic [FREQ_W-1:0] RST_SWEEP_BASE = 23'd34953;
    localparam logic [FREQ_W-1:0] RST_SWEEP_SPAN = 23'd1013613;
    localparam logic [GAIN_W-1:0] RST_DEPTH      = 17'd52429;
    localparam logic [FB_W-1:0]   RST_FEEDBACK   = 16'd32768;
    localparam logic [GAIN_W-1:0] RST_MIX        = 17'd32768;
    localparam logic [GAIN_W-1:0] GAIN_ONE       = 17'd65536;

    localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP = 3'd0,
        CFG_SWEEP_BASE = 3'd1,
        CFG_SWEEP_SPAN = 3'd2,
        CFG_DEPTH      = 3'd3,
        CFG_FEEDBACK   = 3'd4,
        CFG_MIX        = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LIDX,
        OP_LFO,
        OP_SW1,
        OP_SW2,
        OP_KIDX,
        OP_COEF,
        OP_FB,
        OP_SEC,
        OP_MIX1,
        OP_MIX2,
        OP_LOAD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic ch;
    } t_cmd;

    typedef struct packed {
        logic signed [63:0] c;
        logic signed [63:0] s;
    } t_sc;

    function automatic logic signed [SAMPLE_W-1:0] sat24(input longint v);
        if (v > SAMPLE_MAX) begin
            return SAMPLE_W'(SAMPLE_MAX);
        end else if (v < SAMPLE_MIN) begin
            return SAMPLE_W'(SAMPLE_MIN);
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // Rotate by z (turns * 2^32), Q2.30 result.
    function automatic t_sc cordic(input longint z_in);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        t_sc    r;
        x = CORDIC_GAIN;
        y = 0;
        z = z_in;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURNS[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURNS[i];
            end
        end
        r.c = x;
        r.s = y;
        return r;
    endfunction

    // u: phase of the entry, unsigned turns * 2^32.
    function automatic longint lfo_value(input longint u_in);
        longint u;
        longint z;
        longint s;
        t_sc    r;
        u = u_in;
        if (u >= 64'h40000000 && u < 64'hC0000000) begin
            u = (64'h80000000 - u) & 64'hFFFFFFFF;
        end
        z = (u >= 64'h80000000) ? u - 64'h100000000 : u;
        r = cordic(z);
        s = r.s;
        if (s > ONE_Q30) begin
            s = ONE_Q30;
        end
        if (s < -ONE_Q30) begin
            s = -ONE_Q30;
        end
        return (ONE_Q30 + s) >>> 7;
    endfunction

    // Sine of the coefficient angle, Q2.30.
    function automatic longint coef_sin(input longint z);
        t_sc    r;
        longint s;
        r = cordic(z);
        s = r.s;
        return s;
    endfunction

    // Cosine of the coefficient angle, Q2.30, held at one LSB or above.
    function automatic longint coef_cos(input longint z);
        t_sc    r;
        longint c;
        r = cordic(z);
        c = r.c;
        if (c <= 0) begin
            c = 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/sap_ctrl.sv =====
// Frame sequencer of the phaser: steps the datapath through one stereo item.
`default_nettype none
module sap_ctrl
    import sap_pkg::*;
#(
    parameter int STAGES = 4,
    parameter int ST_W   = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_ready,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output t_cmd                 o_cmd,
    output logic [ST_W-1:0]      o_st
);

    typedef enum logic [3:0] {
        S_IDLE, S_LIDX, S_LFO, S_SW1, S_SW2, S_KIDX, S_COEF,
        S_FB, S_SEC, S_MIX1, S_MIX2, S_LOAD
    } t_state;

    t_state            r_state, n_state;
    logic              r_ch, n_ch;
    logic [ST_W-1:0]   r_st, n_st;
    logic              r_out_valid, n_out_valid;
    logic              w_load;

    assign w_load = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_st        = r_st;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_LIDX;
            S_LIDX: n_state = S_LFO;
            S_LFO:  n_state = S_SW1;
            S_SW1:  n_state = S_SW2;
            S_SW2:  n_state = S_KIDX;
            S_KIDX: n_state = S_COEF;
            S_COEF: begin
                n_state = S_FB;
                n_ch    = 1'b0;
            end
            S_FB: begin
                n_state = S_SEC;
                n_st    = '0;
            end
            S_SEC: begin
                if (r_st == ST_W'(STAGES - 1)) begin
                    n_state = S_MIX1;
                end else begin
                    n_st = r_st + 1'b1;
                end
            end
            S_MIX1: n_state = S_MIX2;
            S_MIX2: begin
                if (r_ch) begin
                    n_state = S_LOAD;
                end else begin
                    n_ch    = 1'b1;
                    n_state = S_FB;
                end
            end
            S_LOAD: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= 1'b0;
            r_st        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd.ch = r_ch;
        unique case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_ACCEPT : OP_NONE;
            S_LIDX:  o_cmd.op = OP_LIDX;
            S_LFO:   o_cmd.op = OP_LFO;
            S_SW1:   o_cmd.op = OP_SW1;
            S_SW2:   o_cmd.op = OP_SW2;
            S_KIDX:  o_cmd.op = OP_KIDX;
            S_COEF:  o_cmd.op = OP_COEF;
            S_FB:    o_cmd.op = OP_FB;
            S_SEC:   o_cmd.op = OP_SEC;
            S_MIX1:  o_cmd.op = OP_MIX1;
            S_MIX2:  o_cmd.op = OP_MIX2;
            S_LOAD:  o_cmd.op = w_load ? OP_LOAD : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_st        = r_st;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== design/sap_datapath.sv =====
// Phaser datapath: registers, LFO and coefficient tables, shared arithmetic.
`default_nettype none
module sap_datapath
    import sap_pkg::*;
#(
    parameter int STAGES      = 4,
    parameter int TABLE_DEPTH = 1024,
    parameter int ST_W        = 2
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cmd                        i_cmd,
    input  wire logic [ST_W-1:0]             i_st,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic signed [SAMPLE_W-1:0]  i_left_in,
    input  wire logic signed [SAMPLE_W-1:0]  i_right_in,
    output logic signed [SAMPLE_W-1:0]       o_left_out,
    output logic signed [SAMPLE_W-1:0]       o_right_out
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int NSLOT  = 2 * STAGES;
    localparam int SLOT_W = $clog2(NSLOT);

    // Tables, built at elaboration.
    logic        [LFO_W-1:0] w_lfo_rom  [TABLE_DEPTH];
    logic signed [K_W-1:0]   w_coef_rom [TABLE_DEPTH];

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_rom
        localparam longint LU = (longint'(gi) <<< 32) / TABLE_DEPTH;
        localparam longint KZ = (longint'(gi) <<< 32) / (4 * TABLE_DEPTH) - 64'sd536870912;
        localparam longint LV = lfo_value(LU);
        localparam longint KS = coef_sin(KZ);
        localparam longint KC = coef_cos(KZ);
        localparam longint KV = (KS * 64'sd4194304) / KC;
        assign w_lfo_rom[gi]  = LV[LFO_W-1:0];
        assign w_coef_rom[gi] = KV[K_W-1:0];
    end

    // Configuration.
    logic [STEP_W-1:0] r_phase_step;
    logic [FREQ_W-1:0] r_sweep_base;
    logic [FREQ_W-1:0] r_sweep_span;
    logic [GAIN_W-1:0] r_depth;
    logic [FB_W-1:0]   r_feedback;
    logic [GAIN_W-1:0] r_mix_cfg;

    // State.
    logic [PHASE_W-1:0]        r_phase;
    logic signed [SAMPLE_W-1:0] r_in_prev  [NSLOT];
    logic signed [SAMPLE_W-1:0] r_out_prev [NSLOT];
    logic signed [SAMPLE_W-1:0] r_wet      [2];

    // Per-item work registers.
    logic signed [SAMPLE_W-1:0] r_dry [2];
    logic signed [SAMPLE_W-1:0] r_res [2];
    logic [IDX_W-1:0]           r_lidx;
    logic [LFO_W-1:0]           r_lfo;
    logic [FREQ_W-1:0]          r_sweep;
    logic [FREQ_W-1:0]          r_w;
    logic [IDX_W-1:0]           r_kidx;
    logic signed [K_W-1:0]      r_k;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [41:0]         r_mixacc;
    logic signed [SAMPLE_W-1:0] r_left_out;
    logic signed [SAMPLE_W-1:0] r_right_out;

    logic [SLOT_W-1:0]          w_slot;
    logic [63:0]                w_lprod;
    logic [63:0]                w_kprod;
    logic [47:0]                w_sw1_prod;
    logic [39:0]                w_sw2_prod;
    logic [24:0]                w_wsum;
    logic signed [40:0]         w_fb_prod;
    logic signed [SAMPLE_W-1:0] w_fb_x;
    logic signed [24:0]         w_sec_diff;
    logic signed [49:0]         w_sec_prod;
    logic signed [SAMPLE_W-1:0] w_sec_y;
    logic [GAIN_W-1:0]          w_wet_gain;
    logic [GAIN_W-1:0]          w_dry_gain;
    logic signed [41:0]         w_dry_prod;
    logic signed [41:0]         w_wet_prod;
    logic signed [42:0]         w_mix_sum;
    logic signed [SAMPLE_W-1:0] w_mix_out;

    assign w_slot     = SLOT_W'({i_st, i_cmd.ch});
    assign w_lprod    = 64'(r_phase) * 64'(TABLE_DEPTH);
    assign w_kprod    = 64'(r_w) * 64'(2 * TABLE_DEPTH);
    assign w_sw1_prod = 48'(r_sweep_span) * 48'(r_lfo);
    assign w_sw2_prod = 40'(r_sweep) * 40'(r_depth);
    assign w_wsum     = 25'(w_sw2_prod[39:16]) + 25'(r_sweep_base);

    assign w_fb_prod  = r_wet[i_cmd.ch] * $signed({1'b0, r_feedback});
    assign w_fb_x     = sat24(64'(w_fb_prod >>> 16) + 64'(r_dry[i_cmd.ch]));

    assign w_sec_diff = 25'(r_x) - 25'(r_out_prev[w_slot]);
    assign w_sec_prod = r_k * w_sec_diff;
    assign w_sec_y    = sat24(64'(w_sec_prod >>> 22) + 64'(r_in_prev[w_slot]));

    // Mix above one counts as all wet.
    assign w_wet_gain = (r_mix_cfg > GAIN_ONE) ? GAIN_ONE : r_mix_cfg;
    assign w_dry_gain = GAIN_ONE - w_wet_gain;
    assign w_dry_prod = r_dry[i_cmd.ch] * $signed({1'b0, w_dry_gain});
    assign w_wet_prod = r_x * $signed({1'b0, w_wet_gain});
    assign w_mix_sum  = 43'(r_mixacc) + 43'(w_wet_prod);
    assign w_mix_out  = sat24(64'(w_mix_sum >>> 16));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= RST_PHASE_STEP;
            r_sweep_base <= RST_SWEEP_BASE;
            r_sweep_span <= RST_SWEEP_SPAN;
            r_depth      <= RST_DEPTH;
            r_feedback   <= RST_FEEDBACK;
            r_mix_cfg    <= RST_MIX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data[STEP_W-1:0];
                CFG_SWEEP_BASE: r_sweep_base <= i_cfg_data[FREQ_W-1:0];
                CFG_SWEEP_SPAN: r_sweep_span <= i_cfg_data[FREQ_W-1:0];
                CFG_DEPTH:      r_depth      <= i_cfg_data[GAIN_W-1:0];
                CFG_FEEDBACK:   r_feedback   <= i_cfg_data[FB_W-1:0];
                CFG_MIX:        r_mix_cfg    <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_wet[0] <= '0;
            r_wet[1] <= '0;
            for (int i = 0; i < NSLOT; i++) begin
                r_in_prev[i]  <= '0;
                r_out_prev[i] <= '0;
            end
        end else begin
            case (i_cmd.op)
                OP_LIDX: r_phase <= r_phase + PHASE_W'(r_phase_step);
                OP_SEC: begin
                    r_in_prev[w_slot]  <= r_x;
                    r_out_prev[w_slot] <= w_sec_y;
                end
                OP_MIX1: r_wet[i_cmd.ch] <= r_x;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_dry[0] <= i_left_in;
                r_dry[1] <= i_right_in;
            end
            OP_LIDX: r_lidx  <= w_lprod[32 +: IDX_W];
            OP_LFO:  r_lfo   <= w_lfo_rom[r_lidx];
            OP_SW1:  r_sweep <= w_sw1_prod[24 +: FREQ_W];
            OP_SW2:  r_w     <= w_wsum[24:FREQ_W] != '0 ? '1 : w_wsum[FREQ_W-1:0];
            OP_KIDX: r_kidx  <= w_kprod[24 +: IDX_W];
            OP_COEF: r_k     <= w_coef_rom[r_kidx];
            OP_FB:   r_x     <= w_fb_x;
            OP_SEC:  r_x     <= w_sec_y;
            OP_MIX1: r_mixacc <= w_dry_prod;
            OP_MIX2: r_res[i_cmd.ch] <= w_mix_out;
            OP_LOAD: begin
                r_left_out  <= r_res[0];
                r_right_out <= r_res[1];
            end
            default: ;
        endcase
    end

    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

endmodule
`default_nettype wire

// ===== design/stereo_allpass_phaser_core.sv =====
// Top level of the stereo all-pass phaser: sequencer plus datapath.
`default_nettype none
// One item is one stereo frame. A sine LFO read from a table sweeps the
// corner frequency of a chain of STAGES first-order all-pass sections per
// channel; the section coefficient comes from a second table, the last wet
// sample of each channel is fed back into the chain, and the wet signal is
// mixed with the dry input and saturated to 24 bits. After acceptance an
// item runs through the LFO, sweep and coefficient lookup steps, then per
// channel through a feedback step, a section step for each section through
// the single shared section multiplier and the mix steps, and last through
// a load step, which waits until the output register is free to take it.
// The next item is accepted once the previous one has been loaded into the
// output register, even while that result still waits to be taken. Both
// tables hold TABLE_DEPTH entries and are built at elaboration; there is no
// clearing pass. Configuration writes are taken in every cycle; the user
// must keep them to the idle block, as the block does not enforce it.
module stereo_allpass_phaser_core
    import sap_pkg::*;
#(
    parameter int STAGES      = 4,
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_left_in,
    input  wire logic signed [SAMPLE_W-1:0] i_right_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0]      o_left_out,
    output logic signed [SAMPLE_W-1:0]      o_right_out,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int ST_W = (STAGES > 1) ? $clog2(STAGES) : 1;

    t_cmd            w_cmd;
    logic [ST_W-1:0] w_st;

    // Register writes never stall.
    assign o_cfg_ready = 1'b1;

    sap_ctrl #(
        .STAGES (STAGES),
        .ST_W   (ST_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .o_st        (w_st)
    );

    sap_datapath #(
        .STAGES      (STAGES),
        .TABLE_DEPTH (TABLE_DEPTH),
        .ST_W        (ST_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_st        (w_st),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out)
    );

endmodule
`default_nettype wire
